>>> rtl/rtalu_pkg.sv
package rtalu_pkg;

   localparam int DataWidth = 32;
   localparam int RegCount  = 32;
   localparam int AddrWidth = $clog2(RegCount);
   localparam int RetReg    = 28;

   localparam logic [5:0] FN_ADD  = 6'b100000;
   localparam logic [5:0] FN_SUB  = 6'b100010;
   localparam logic [5:0] FN_MOV  = 6'b001001;
   localparam logic [5:0] FN_MUL  = 6'b011001;
   localparam logic [5:0] FN_MULH = 6'b011000;
   localparam logic [5:0] FN_DIV  = 6'b011010;
   localparam logic [5:0] FN_REM  = 6'b011011;
   localparam logic [5:0] FN_IN   = 6'b101010;
   localparam logic [5:0] FN_OUT  = 6'b010101;
   localparam logic [5:0] FN_JR   = 6'b001000;
   localparam logic [5:0] FN_RETL = 6'b111111;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request
      logic read;       // latch register operands
      logic exec;       // compute non-divide results, start divider
      logic div_step;   // one quotient bit
      logic write;      // write back to the register file
      logic rsp_load;   // load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_div;
      logic div_done;
   } status_type;

endpackage

>>> rtl/rtype_alu_register_file_unit.sv
// R-type ALU with a 32 x 32-bit register file.
// The request channel carries one instruction word and a value for the in
// operation per transaction. Each request yields exactly one response
// transaction on the rsp channel carrying jump and output-byte fields.
// The block works on one instruction at a time: a transaction is accepted,
// the operands are read, the operation executes, the register file is
// written and the response is presented. Operations other than divide and
// remainder pass through the READ, EXEC, WRITE and RESP states; divide and
// remainder add the DIV state between EXEC and WRITE, where the restoring
// divider produces one quotient bit per cycle. A new request is accepted
// the cycle after the response transaction completes.
// A stalled receiver simply holds the response; the request channel stays
// not ready until the response is taken.
// Reset (synchronous, active high) clears all registers of the register
// file to zero and returns the controller to idle.
module rtype_alu_register_file_unit #(
   parameter int DATA_WIDTH = rtalu_pkg::DataWidth,
   parameter int REG_COUNT  = rtalu_pkg::RegCount
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // instr[31:0], in_value[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // jump_valid[0], jump_target[32:1],
                                    // out_valid[33], out_byte[41:34], zero
);
   import rtalu_pkg::*;
   cmd_type    cmd;
   status_type status;
   logic jv, ov;
   logic [DATA_WIDTH-1:0] jt;
   logic [7:0] ob;

   rtalu_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   rtalu_datapath #(.DATA_WIDTH(DATA_WIDTH), .REG_COUNT(REG_COUNT)) u_dp (
      .clock, .reset, .cmd, .status,
      .instr(req_tdata[31:0]),
      .in_value(req_tdata[32 +: DATA_WIDTH]),
      .jump_valid(jv), .jump_target(jt), .out_valid(ov), .out_byte(ob)
   );

   assign rsp_tdata = {6'd0, ob, ov, jt, jv};

   // Requests are refused while a response is pending.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("request accepted while response pending");
   // Jump and out are never reported together.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !(jv && ov))
      else $error("jump and out both set");
   // A completed response returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not idle after response");
endmodule

>>> rtl/rtalu_datapath.sv
module rtalu_datapath #(
   parameter int DATA_WIDTH = rtalu_pkg::DataWidth,
   parameter int REG_COUNT  = rtalu_pkg::RegCount
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rtalu_pkg::cmd_type     cmd,
   output rtalu_pkg::status_type  status,
   input  logic [31:0]            instr,
   input  logic [DATA_WIDTH-1:0]  in_value,
   output logic                   jump_valid,
   output logic [DATA_WIDTH-1:0]  jump_target,
   output logic                   out_valid,
   output logic [7:0]             out_byte
);
   import rtalu_pkg::*;
   localparam int AW = $clog2(REG_COUNT);
   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [REG_COUNT-1:0][DATA_WIDTH-1:0] regs_ff, regs_in;
   logic [31:0] instr_ff;
   logic [DATA_WIDTH-1:0] inval_ff, a_ff, b_ff, ret_ff, wdata_ff, wdata_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic wen_ff, wen_in;
   logic [DATA_WIDTH-1:0] quo_ff, rem_ff;
   logic [CW-1:0] cnt_ff;
   logic jv_ff, ov_ff;
   logic [DATA_WIDTH-1:0] jt_ff;
   logic [7:0] ob_ff;
   logic [5:0] fn;
   logic [AW-1:0] rs, rt, rd;
   logic [2*DATA_WIDTH-1:0] prod;
   logic [DATA_WIDTH:0] trial;

   assign fn = instr_ff[5:0];
   assign rs = instr_ff[21 +: AW];
   assign rt = instr_ff[16 +: AW];
   assign rd = instr_ff[11 +: AW];
   assign prod = {{DATA_WIDTH{1'b0}}, a_ff} * {{DATA_WIDTH{1'b0}}, b_ff};
   // The shifted partial remainder needs one bit more than the data width.
   assign trial = {rem_ff, quo_ff[DATA_WIDTH-1]} - {1'b0, b_ff};

   assign status.is_div   = (fn == FN_DIV) || (fn == FN_REM);
   assign status.div_done = (cnt_ff == CW'(DATA_WIDTH));

   always_comb begin
      wen_in   = 1'b0;
      waddr_in = rd;
      wdata_in = '0;
      case (fn)
         FN_ADD:  begin wen_in = 1'b1; wdata_in = a_ff + b_ff; end
         FN_SUB:  begin wen_in = 1'b1; wdata_in = a_ff - b_ff; end
         FN_MOV:  begin wen_in = 1'b1; waddr_in = rt; wdata_in = a_ff; end
         FN_MUL:  begin wen_in = 1'b1; wdata_in = prod[DATA_WIDTH-1:0]; end
         FN_MULH: begin wen_in = 1'b1; wdata_in = prod[2*DATA_WIDTH-1:DATA_WIDTH]; end
         FN_IN:   begin wen_in = 1'b1; waddr_in = rs; wdata_in = inval_ff; end
         default: begin wen_in = 1'b0; end
      endcase
   end

   always_comb begin
      regs_in = regs_ff;
      if (cmd.write && wen_ff) begin
         regs_in[waddr_ff] = wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         instr_ff <= instr;
         inval_ff <= in_value;
      end
      if (cmd.read) begin
         a_ff   <= regs_ff[rs];
         b_ff   <= regs_ff[rt];
         ret_ff <= regs_ff[AW'(RetReg)];
      end
      if (cmd.exec) begin
         wen_ff   <= wen_in;
         waddr_ff <= waddr_in;
         wdata_ff <= wdata_in;
         quo_ff   <= a_ff;
         rem_ff   <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[DATA_WIDTH]) begin
            rem_ff <= trial[DATA_WIDTH-1:0];
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DATA_WIDTH-2:0], quo_ff[DATA_WIDTH-1]};
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (status.div_done) begin
            wen_ff   <= 1'b1;
            wdata_ff <= (fn == FN_DIV) ? quo_ff : rem_ff;
         end
      end
      if (cmd.rsp_load) begin
         jv_ff <= (fn == FN_JR) || (fn == FN_RETL);
         jt_ff <= (fn == FN_JR) ? a_ff - 1'b1 : ((fn == FN_RETL) ? ret_ff : '0);
         ov_ff <= (fn == FN_OUT);
         ob_ff <= (fn == FN_OUT) ? a_ff[7:0] : 8'd0;
      end
   end

   assign jump_valid  = jv_ff;
   assign jump_target = jt_ff;
   assign out_valid   = ov_ff;
   assign out_byte    = ob_ff;
endmodule

>>> rtl/rtalu_controller.sv
module rtalu_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  rtalu_pkg::status_type status,
   output rtalu_pkg::cmd_type    cmd
);
   import rtalu_pkg::*;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = status.is_div ? ST_DIV : ST_WRITE;
         ST_DIV:   if (status.div_done) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_RESP:  if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE:  begin req_tready = 1'b1; cmd.load = req_tvalid; end
         ST_READ:  cmd.read = 1'b1;
         ST_EXEC:  cmd.exec = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_WRITE: begin cmd.write = 1'b1; cmd.rsp_load = 1'b1; end
         ST_RESP:  rsp_tvalid = 1'b1;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> sim/tb_rtype_alu_register_file_unit.sv
module tb_rtype_alu_register_file_unit;
   import rtalu_pkg::*;

   // One request transaction: an instruction word and the value for IN.
   // Packed so that the instruction lands in the low half of req_tdata.
   typedef struct packed {
      logic [31:0] in_value;
      logic [31:0] instr;
   } instr_item_t;

   // One response transaction as the block reports it, lowest field last.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic [31:0] jump_target;
      logic        jump_valid;
   } outcome_t;

   localparam int MaxCycles = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   rtype_alu_register_file_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the register file, advanced as each request is accepted.
   logic [31:0] shadow_regs [32];

   instr_item_t pending_instrs [$];
   outcome_t    expected_outcomes [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          stimulus_done = 1'b0;
   bit          hold_sender = 1'b0;

   // Executes one instruction on the shadow register file and returns the
   // response that the block should give for it.
   function automatic outcome_t execute_instr(input instr_item_t item);
      logic [5:0]  fn;
      logic [4:0]  rs, rt, rd;
      logic [31:0] a, b;
      logic [63:0] prod;
      outcome_t    res;
      fn = item.instr[5:0];
      rs = item.instr[25:21];
      rt = item.instr[20:16];
      rd = item.instr[15:11];
      a = shadow_regs[rs];
      b = shadow_regs[rt];
      res = '0;
      case (fn)
         FN_ADD:  shadow_regs[rd] = a + b;
         FN_SUB:  shadow_regs[rd] = a - b;
         FN_MOV:  shadow_regs[rt] = a;
         FN_MUL:  shadow_regs[rd] = a * b;
         FN_MULH: begin
            prod = {32'd0, a} * {32'd0, b};
            shadow_regs[rd] = prod[63:32];
         end
         FN_DIV:  shadow_regs[rd] = (b == 0) ? 32'hFFFF_FFFF : a / b;
         FN_REM:  shadow_regs[rd] = (b == 0) ? a : a % b;
         FN_IN:   shadow_regs[rs] = item.in_value;
         FN_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = a[7:0];
         end
         FN_JR: begin
            res.jump_valid  = 1'b1;
            res.jump_target = a - 32'd1;
         end
         FN_RETL: begin
            res.jump_valid  = 1'b1;
            res.jump_target = shadow_regs[RetReg];
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic bit execute_instr_and_queue(input instr_item_t item);
      expected_outcomes.push_back(execute_instr(item));
      return 1'b1;
   endfunction

   function automatic logic [31:0] make_instr(input logic [5:0] fn, input logic [4:0] rs,
                                              input logic [4:0] rt, input logic [4:0] rd);
      logic [31:0] w;
      // Unused bits carry random junk, which the block must ignore.
      w = $urandom;
      w[25:21] = rs;
      w[20:16] = rt;
      w[15:11] = rd;
      w[5:0]   = fn;
      return w;
   endfunction

   function automatic logic [5:0] random_fn();
      logic [5:0] codes [11];
      codes = '{FN_ADD, FN_SUB, FN_MOV, FN_MUL, FN_MULH, FN_DIV, FN_REM,
                FN_IN, FN_OUT, FN_JR, FN_RETL};
      // Mostly legal codes, with some arbitrary (often unknown) codes.
      if ($urandom_range(0, 9) == 0) return 6'($urandom);
      return codes[$urandom_range(0, 10)];
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(0, 15));
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_instr(input logic [31:0] instr, input logic [31:0] in_value);
      instr_item_t item;
      item.instr = instr;
      item.in_value = in_value;
      pending_instrs.push_back(item);
   endtask

   // Stimulus: directed cases first, then random items.
   initial begin
      foreach (shadow_regs[i]) shadow_regs[i] = '0;
      // Extremes of the operands and each operation.
      push_instr(make_instr(FN_IN, 5'd1, 5'd0, 5'd0), 32'hFFFF_FFFF);
      push_instr(make_instr(FN_IN, 5'd2, 5'd0, 5'd0), 32'hFFFF_FFFF);
      push_instr(make_instr(FN_IN, 5'd31, 5'd0, 5'd0), 32'h0000_0007);
      push_instr(make_instr(FN_ADD, 5'd1, 5'd2, 5'd3), 32'd0);
      push_instr(make_instr(FN_SUB, 5'd0, 5'd1, 5'd4), 32'd0);
      push_instr(make_instr(FN_MUL, 5'd1, 5'd2, 5'd5), 32'd0);
      push_instr(make_instr(FN_MULH, 5'd1, 5'd2, 5'd6), 32'd0);
      // Division and remainder by zero, then by a real divisor.
      push_instr(make_instr(FN_DIV, 5'd1, 5'd0, 5'd7), 32'd0);
      push_instr(make_instr(FN_REM, 5'd1, 5'd0, 5'd8), 32'd0);
      push_instr(make_instr(FN_DIV, 5'd1, 5'd31, 5'd9), 32'd0);
      push_instr(make_instr(FN_REM, 5'd1, 5'd31, 5'd10), 32'd0);
      push_instr(make_instr(FN_MOV, 5'd31, 5'd11, 5'd0), 32'd0);
      push_instr(make_instr(FN_OUT, 5'd1, 5'd0, 5'd0), 32'd0);
      push_instr(make_instr(FN_OUT, 5'd31, 5'd0, 5'd0), 32'd0);
      // A jump through register zero wraps to all ones.
      push_instr(make_instr(FN_JR, 5'd0, 5'd0, 5'd0), 32'd0);
      push_instr(make_instr(FN_JR, 5'd31, 5'd0, 5'd0), 32'd0);
      push_instr(make_instr(FN_IN, 5'd28, 5'd0, 5'd0), 32'h1234_5678);
      push_instr(make_instr(FN_RETL, 5'd0, 5'd0, 5'd0), 32'd0);
      // Register zero is written like any other register.
      push_instr(make_instr(FN_ADD, 5'd1, 5'd31, 5'd0), 32'd0);
      push_instr(make_instr(FN_OUT, 5'd0, 5'd0, 5'd0), 32'd0);
      // An unknown code changes nothing.
      push_instr(make_instr(6'b000000, 5'd1, 5'd2, 5'd3), 32'd0);
      push_instr(make_instr(FN_OUT, 5'd3, 5'd0, 5'd0), 32'd0);
      push_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < 1100; i++) begin
         // Keep registers loaded with interesting values via IN.
         if ($urandom_range(0, 3) == 0)
            push_instr(make_instr(FN_IN, 5'($urandom), 5'($urandom), 5'($urandom)),
                       random_value());
         else
            push_instr(make_instr(random_fn(), 5'($urandom), 5'($urandom), 5'($urandom)),
                       $urandom);
      end
      // Pause the sender once mid-run until every response has drained.
      wait (pending_instrs.size() < 600);
      hold_sender = 1'b1;
      wait (expected_outcomes.size() == 0 && !req_tvalid);
      hold_sender = 1'b0;
      stimulus_done = 1'b1;
   end

   // Driver: bursts of transactions separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // Hold the current transaction until the block takes it.
      end else begin
         if (req_tvalid && req_tready) begin
            void'(execute_instr_and_queue(pending_instrs[0]));
            void'(pending_instrs.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (hold_sender || pending_instrs.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_instrs[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(0, 12);
               if ($urandom_range(0, 1)) gap_left <= $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Monitor: compare each response transaction with the oldest expectation.
   always @(posedge clock) begin
      outcome_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[41:0];
         if (expected_outcomes.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (got.jump_valid !== want.jump_valid) begin
               $display("%0t: jump_valid expected %b actual %b", $time,
                        want.jump_valid, got.jump_valid);
               error_count++;
            end
            if (got.jump_target !== want.jump_target) begin
               $display("%0t: jump_target expected %h actual %h", $time,
                        want.jump_target, got.jump_target);
               error_count++;
            end
            if (got.out_valid !== want.out_valid) begin
               $display("%0t: out_valid expected %b actual %b", $time,
                        want.out_valid, got.out_valid);
               error_count++;
            end
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time,
                        want.out_byte, got.out_byte);
               error_count++;
            end
         end
      end
   end

   // Receiver stall pattern: alternating phases of always-ready and
   // randomly stalled, so responses are sometimes held before being taken.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (cycle_count[9])
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // Reset, end of run and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 1) reset <= 1'b0;
      if (cycle_count >= MaxCycles) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done && pending_instrs.size() == 0 && !req_tvalid &&
            expected_outcomes.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
